FILE: hw/rtl/twm_pkg.sv
// Shared types and constants for the timing wheel timer manager.
// Used by twm_div and timing_wheel_timer_manager; depends on nothing.

package twm_pkg;

    localparam int TIMEOUT_W   = 16;
    localparam int HANDLE_W    = 5;
    localparam int TAG_W       = 16;
    localparam int KIND_W      = 3;
    localparam int RSLOT_W     = 6;
    localparam int ROT_W       = 9;
    localparam int ROT_MAX     = 511;
    localparam int MAX_RESULTS = 32;
    localparam int NRES_W      = 6;

    // Shared divider widths: 15-bit non-negative dividend, divisor up to 2047,
    // reciprocal floor(2^RECIP_SH / divisor) in RECIP_W bits.
    localparam int DIVIDEND_W  = 15;
    localparam int DIVISOR_W   = 11;
    localparam int RECIP_SH    = 26;
    localparam int RECIP_W     = 27;

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_DEL  = 2'd1,
        OP_TICK = 2'd2
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADDED     = 3'd0,
        KIND_REJECTED  = 3'd1,
        KIND_FULL      = 3'd2,
        KIND_DELETED   = 3'd3,
        KIND_NOT_FOUND = 3'd4,
        KIND_EXPIRED   = 3'd5,
        KIND_TICK_NONE = 3'd6
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEC,
        S_FIND,
        S_DIV_T,
        S_DIV_S,
        S_ADD_WR,
        S_TICK_RD,
        S_TICK_EV,
        S_TICK_END
    } t_state;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
        logic [RECIP_W-1:0]    recip;
    } t_div_req;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
        logic [DIVISOR_W-1:0]  remainder;
    } t_div_rsp;

endpackage

FILE: hw/rtl/twm_div.sv
// Divider by a constant: reciprocal multiply, back multiply, one correction.
// Depends on twm_pkg for widths and the request/response structs.

module twm_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  twm_pkg::t_div_req i_req,
    output twm_pkg::t_div_rsp o_rsp
);

    localparam int DD_W = twm_pkg::DIVIDEND_W;
    localparam int DV_W = twm_pkg::DIVISOR_W;
    localparam int SH   = twm_pkg::RECIP_SH;
    localparam int PR_W = DD_W + SH;
    localparam int BK_W = DD_W + DV_W;

    logic            r_s1;
    logic            r_s2;
    logic            r_done;
    logic [PR_W-1:0] r_prod;
    logic [DD_W-1:0] r_x;
    logic [DV_W-1:0] r_dvs;
    logic [DD_W-1:0] r_q0;
    logic [BK_W-1:0] r_back;
    logic [DD_W-1:0] r_quo;
    logic [DV_W-1:0] r_rem;

    logic [PR_W-1:0] w_prod;
    logic [DD_W-1:0] w_q0;
    logic [BK_W-1:0] w_back;
    logic [DV_W:0]   w_r0;
    logic            w_fix;

    // estimate is the true quotient or one below it
    assign w_prod = PR_W'(i_req.dividend) * PR_W'(i_req.recip);
    assign w_q0   = r_prod[SH +: DD_W];
    assign w_back = BK_W'(w_q0) * BK_W'(r_dvs);
    assign w_r0   = (DV_W + 1)'(BK_W'(r_x) - r_back);
    assign w_fix  = (w_r0 >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1   <= 1'b0;
            r_s2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_s1   <= i_req.start;
            r_s2   <= r_s1;
            r_done <= r_s2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_prod <= w_prod;
            r_x    <= i_req.dividend;
            r_dvs  <= i_req.divisor;
        end
        if (r_s1) begin
            r_q0   <= w_q0;
            r_back <= w_back;
        end
        if (r_s2) begin
            r_quo <= w_fix ? r_q0 + DD_W'(1) : r_q0;
            r_rem <= w_fix ? DV_W'(w_r0 - {1'b0, r_dvs}) : w_r0[DV_W-1:0];
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

FILE: hw/rtl/timing_wheel_timer_manager.sv
// Hashed timing wheel timer manager: sequencer, entry pool memory, output register.
// Depends on twm_pkg and on twm_div, the divider shared by both add divisions.
//
//   channel | direction | handshake                 | word fields
//   in      | input     | i_in_valid / o_in_stall   | opcode, timeout, handle, user_tag
//   out     | output    | o_out_valid / i_out_stall | kind, result_handle, result_tag,
//           |           |                           | result_slot, result_rotation, last
//
// Delete, rejected add: answered from S_DEC. Add: S_DEC, S_FIND past each live entry below
// the free one (full pool: past every entry), two divider passes, one write in S_ADD_WR.
// Tick: S_DEC, S_TICK_RD per entry and S_TICK_EV after it per live entry (pool memory read
// is registered), then S_TICK_END. Synchronous active-low reset clears the pool valid bits,
// the current slot and all control; no memory sweep. Input stall stays high until the last
// word is loaded; output stall holds the sequencer only when a word meets a full register.

module timing_wheel_timer_manager #(
    parameter int WHEEL_SLOTS   = 64,
    parameter int TICK_INTERVAL = 1,
    parameter int MAX_TIMERS    = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic signed [twm_pkg::TIMEOUT_W-1:0] i_timeout,
    input  logic [twm_pkg::HANDLE_W-1:0]         i_handle,
    input  logic [twm_pkg::TAG_W-1:0]            i_user_tag,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [twm_pkg::KIND_W-1:0]           o_kind,
    output logic [twm_pkg::HANDLE_W-1:0]         o_result_handle,
    output logic [twm_pkg::TAG_W-1:0]            o_result_tag,
    output logic [twm_pkg::RSLOT_W-1:0]          o_result_slot,
    output logic [twm_pkg::ROT_W-1:0]            o_result_rotation,
    output logic        o_last
);

    localparam int IDX_W  = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int CNT_W  = $clog2(MAX_TIMERS + 1);
    localparam int SLOT_W = $clog2(WHEEL_SLOTS);
    localparam int ROT_W  = twm_pkg::ROT_W;
    localparam int TAG_W  = twm_pkg::TAG_W;
    localparam int HND_W  = twm_pkg::HANDLE_W;
    localparam int NRES_W = twm_pkg::NRES_W;
    localparam int DD_W   = twm_pkg::DIVIDEND_W;
    localparam int DV_W   = twm_pkg::DIVISOR_W;
    localparam int RC_W   = twm_pkg::RECIP_W;
    localparam int MEM_W  = SLOT_W + ROT_W + TAG_W;

    localparam logic [CNT_W-1:0]  CNT_END   = CNT_W'(MAX_TIMERS);
    localparam logic [SLOT_W:0]   SLOTS_C   = (SLOT_W + 1)'(WHEEL_SLOTS);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WHEEL_SLOTS - 1);
    localparam logic [NRES_W-1:0] NRES_END  = NRES_W'(twm_pkg::MAX_RESULTS);
    localparam logic [RC_W-1:0]   RECIP_TI  =
        RC_W'((64'd1 << twm_pkg::RECIP_SH) / TICK_INTERVAL);
    localparam logic [RC_W-1:0]   RECIP_WS  =
        RC_W'((64'd1 << twm_pkg::RECIP_SH) / WHEEL_SLOTS);

    twm_pkg::t_state r_state, n_state;

    // accepted input word
    logic [1:0]        r_op;
    logic [15:0]       r_timeout;
    logic [HND_W-1:0]  r_handle;
    logic [TAG_W-1:0]  r_tag;

    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [NRES_W-1:0] r_n, n_n;
    logic [SLOT_W-1:0] r_cur, n_cur;
    logic [MAX_TIMERS-1:0] r_valid, n_valid;

    // expiry held back until the next one (or scan end) settles its last flag
    logic              r_hv, n_hv;
    logic [IDX_W-1:0]  r_hh, n_hh;
    logic [TAG_W-1:0]  r_ht, n_ht;

    logic              r_o_valid;
    logic [twm_pkg::KIND_W-1:0]  r_o_kind;
    logic [HND_W-1:0]  r_o_handle;
    logic [TAG_W-1:0]  r_o_tag;
    logic [twm_pkg::RSLOT_W-1:0] r_o_slot;
    logic [ROT_W-1:0]  r_o_rot;
    logic              r_o_last;

    logic              e_req;
    twm_pkg::t_kind    e_kind;
    logic [HND_W-1:0]  e_handle;
    logic [TAG_W-1:0]  e_tag;
    logic [twm_pkg::RSLOT_W-1:0] e_slot;
    logic [ROT_W-1:0]  e_rot;
    logic              e_last;
    logic              w_out_free;
    logic              w_out_load;

    logic [MEM_W-1:0]  r_mem [MAX_TIMERS];
    logic [MEM_W-1:0]  r_rd_data;
    logic              w_wr_en;
    logic [MEM_W-1:0]  w_wr_data;

    twm_pkg::t_div_req w_div_req;
    twm_pkg::t_div_rsp w_div_rsp;

    logic [IDX_W-1:0]  w_idx;
    logic [IDX_W-1:0]  w_del_idx;
    logic              w_del_hit;
    logic [DD_W-1:0]   w_ticks;
    logic [SLOT_W:0]   w_sum;
    logic [SLOT_W-1:0] w_slot;
    logic [ROT_W-1:0]  w_rot;
    logic [SLOT_W-1:0] w_rd_slot;
    logic [ROT_W-1:0]  w_rd_rot;
    logic [TAG_W-1:0]  w_rd_tag;
    logic              w_ev_due;
    logic              w_ev_adv;

    twm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign w_idx      = r_cnt[IDX_W-1:0];
    assign w_del_idx  = IDX_W'(r_handle);
    assign w_del_hit  = (32'(r_handle) < MAX_TIMERS) && r_valid[w_del_idx];
    assign w_out_free = !r_o_valid || !i_out_stall;
    assign w_out_load = e_req && w_out_free;

    // ticks = 1 below one interval, else timeout / interval
    assign w_ticks = (w_div_rsp.quotient == '0) ? DD_W'(1) : w_div_rsp.quotient;
    assign w_sum   = {1'b0, r_cur} + {1'b0, SLOT_W'(w_div_rsp.remainder)};
    assign w_slot  = (w_sum >= SLOTS_C) ? SLOT_W'(w_sum - SLOTS_C) : w_sum[SLOT_W-1:0];
    assign w_rot   = (w_div_rsp.quotient > DD_W'(twm_pkg::ROT_MAX)) ?
                     ROT_W'(twm_pkg::ROT_MAX) : w_div_rsp.quotient[ROT_W-1:0];

    assign w_rd_slot = r_rd_data[MEM_W-1 -: SLOT_W];
    assign w_rd_rot  = r_rd_data[TAG_W +: ROT_W];
    assign w_rd_tag  = r_rd_data[TAG_W-1:0];

    // due entry: live, in the current slot, rotation exhausted, result room left
    assign w_ev_due = (w_rd_slot == r_cur) && (w_rd_rot == '0) && (r_n != NRES_END);
    assign w_ev_adv = !w_ev_due || !r_hv || w_out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            twm_pkg::S_IDLE: begin
                if (i_in_valid) n_state = twm_pkg::S_DEC;
            end
            twm_pkg::S_DEC: begin
                case (r_op)
                    twm_pkg::OP_ADD: begin
                        if (!r_timeout[15]) n_state = twm_pkg::S_FIND;
                        else if (w_out_free) n_state = twm_pkg::S_IDLE;
                    end
                    twm_pkg::OP_DEL: begin
                        if (w_out_free) n_state = twm_pkg::S_IDLE;
                    end
                    twm_pkg::OP_TICK: n_state = twm_pkg::S_TICK_RD;
                    default:          n_state = twm_pkg::S_IDLE;
                endcase
            end
            twm_pkg::S_FIND: begin
                if (r_cnt == CNT_END) begin
                    if (w_out_free) n_state = twm_pkg::S_IDLE;
                end else if (!r_valid[w_idx]) begin
                    n_state = twm_pkg::S_DIV_T;
                end
            end
            twm_pkg::S_DIV_T: begin
                if (w_div_rsp.done) n_state = twm_pkg::S_DIV_S;
            end
            twm_pkg::S_DIV_S: begin
                if (w_div_rsp.done) n_state = twm_pkg::S_ADD_WR;
            end
            twm_pkg::S_ADD_WR: begin
                if (w_out_free) n_state = twm_pkg::S_IDLE;
            end
            twm_pkg::S_TICK_RD: begin
                if (r_cnt == CNT_END) n_state = twm_pkg::S_TICK_END;
                else if (r_valid[w_idx]) n_state = twm_pkg::S_TICK_EV;
            end
            twm_pkg::S_TICK_EV: begin
                if (w_ev_adv) n_state = twm_pkg::S_TICK_RD;
            end
            twm_pkg::S_TICK_END: begin
                if (w_out_free) n_state = twm_pkg::S_IDLE;
            end
            default: n_state = twm_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_cnt     = r_cnt;
        n_n       = r_n;
        n_cur     = r_cur;
        n_valid   = r_valid;
        n_hv      = r_hv;
        n_hh      = r_hh;
        n_ht      = r_ht;
        e_req     = 1'b0;
        e_kind    = twm_pkg::KIND_ADDED;
        e_handle  = '0;
        e_tag     = '0;
        e_slot    = '0;
        e_rot     = '0;
        e_last    = 1'b1;
        w_wr_en   = 1'b0;
        w_wr_data = '0;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = r_timeout[DD_W-1:0];
        w_div_req.divisor  = DV_W'(TICK_INTERVAL);
        w_div_req.recip    = RECIP_TI;
        case (r_state)
            twm_pkg::S_IDLE: begin
                n_cnt = '0;
                n_n   = '0;
                n_hv  = 1'b0;
            end
            twm_pkg::S_DEC: begin
                case (r_op)
                    twm_pkg::OP_ADD: begin
                        if (r_timeout[15]) begin
                            e_req  = 1'b1;
                            e_kind = twm_pkg::KIND_REJECTED;
                        end
                    end
                    twm_pkg::OP_DEL: begin
                        e_req    = 1'b1;
                        e_handle = r_handle;
                        if (w_del_hit) begin
                            e_kind = twm_pkg::KIND_DELETED;
                            if (w_out_free) n_valid[w_del_idx] = 1'b0;
                        end else begin
                            e_kind = twm_pkg::KIND_NOT_FOUND;
                        end
                    end
                    default: ;
                endcase
            end
            twm_pkg::S_FIND: begin
                if (r_cnt == CNT_END) begin
                    e_req  = 1'b1;
                    e_kind = twm_pkg::KIND_FULL;
                end else if (!r_valid[w_idx]) begin
                    w_div_req.start = 1'b1;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            twm_pkg::S_DIV_T: begin
                // second pass splits ticks into slot offset and rotation
                if (w_div_rsp.done) begin
                    w_div_req.start    = 1'b1;
                    w_div_req.dividend = w_ticks;
                    w_div_req.divisor  = DV_W'(WHEEL_SLOTS);
                    w_div_req.recip    = RECIP_WS;
                end
            end
            twm_pkg::S_ADD_WR: begin
                e_req    = 1'b1;
                e_kind   = twm_pkg::KIND_ADDED;
                e_handle = HND_W'(w_idx);
                e_slot   = twm_pkg::RSLOT_W'(w_slot);
                e_rot    = w_rot;
                if (w_out_free) begin
                    w_wr_en        = 1'b1;
                    w_wr_data      = {w_slot, w_rot, r_tag};
                    n_valid[w_idx] = 1'b1;
                end
            end
            twm_pkg::S_TICK_RD: begin
                if (r_cnt != CNT_END && !r_valid[w_idx]) n_cnt = r_cnt + CNT_W'(1);
            end
            twm_pkg::S_TICK_EV: begin
                if (w_rd_slot == r_cur && w_rd_rot != '0) begin
                    w_wr_en   = 1'b1;
                    w_wr_data = {w_rd_slot, w_rd_rot - ROT_W'(1), w_rd_tag};
                end
                if (w_ev_due) begin
                    // release the held expiry, not the last one of this tick
                    e_req    = r_hv;
                    e_kind   = twm_pkg::KIND_EXPIRED;
                    e_handle = HND_W'(r_hh);
                    e_tag    = r_ht;
                    e_last   = 1'b0;
                    if (w_ev_adv) begin
                        n_hv           = 1'b1;
                        n_hh           = w_idx;
                        n_ht           = w_rd_tag;
                        n_valid[w_idx] = 1'b0;
                        n_n            = r_n + NRES_W'(1);
                    end
                end
                if (w_ev_adv) n_cnt = r_cnt + CNT_W'(1);
            end
            twm_pkg::S_TICK_END: begin
                e_req = 1'b1;
                if (r_hv) begin
                    e_kind   = twm_pkg::KIND_EXPIRED;
                    e_handle = HND_W'(r_hh);
                    e_tag    = r_ht;
                end else begin
                    e_kind = twm_pkg::KIND_TICK_NONE;
                end
                if (w_out_free) n_cur = (r_cur == SLOT_LAST) ? '0 : r_cur + SLOT_W'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= twm_pkg::S_IDLE;
            r_cnt     <= '0;
            r_n       <= '0;
            r_cur     <= '0;
            r_valid   <= '0;
            r_hv      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_n       <= n_n;
            r_cur     <= n_cur;
            r_valid   <= n_valid;
            r_hv      <= n_hv;
            r_o_valid <= w_out_load || (r_o_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == twm_pkg::S_IDLE && i_in_valid) begin
            r_op      <= i_opcode;
            r_timeout <= i_timeout;
            r_handle  <= i_handle;
            r_tag     <= i_user_tag;
        end
        r_hh <= n_hh;
        r_ht <= n_ht;
        if (w_out_load) begin
            r_o_kind   <= e_kind;
            r_o_handle <= e_handle;
            r_o_tag    <= e_tag;
            r_o_slot   <= e_slot;
            r_o_rot    <= e_rot;
            r_o_last   <= e_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) r_mem[w_idx] <= w_wr_data;
        r_rd_data <= r_mem[w_idx];
    end

    assign o_in_stall        = (r_state != twm_pkg::S_IDLE);
    assign o_out_valid       = r_o_valid;
    assign o_kind            = r_o_kind;
    assign o_result_handle   = r_o_handle;
    assign o_result_tag      = r_o_tag;
    assign o_result_slot     = r_o_slot;
    assign o_result_rotation = r_o_rot;
    assign o_last            = r_o_last;

    a_cur_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cur) < WHEEL_SLOTS)
        else $error("current slot beyond wheel size");

    a_nres_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= NRES_END)
        else $error("tick produced too many expiries");

    a_add_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == twm_pkg::S_ADD_WR && w_out_free) |=> r_valid[$past(w_idx)])
        else $error("added entry not marked live");

    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |-> (r_state == twm_pkg::S_FIND || r_state == twm_pkg::S_DIV_T))
        else $error("divider started outside add sequence");

    a_expire_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == twm_pkg::S_TICK_EV && w_ev_due && w_ev_adv)
        |=> (!r_valid[$past(w_idx)] && r_hv))
        else $error("expired entry still live or not held");

endmodule
